// File: rtl/core/fwfu_pkg.sv
// Shared types, constants and helpers for the fixed-width field unpacker.
package fwfu_pkg;

  localparam int unsigned WordBits  = 64;
  localparam int unsigned DataBits  = 64;
  localparam int unsigned PosW      = $clog2(WordBits + 1);
  localparam int unsigned WidthBits = 7;
  localparam int unsigned CountBits = 32;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 32;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [WidthBits-1:0] WidthReset = WidthBits'(8);
  localparam logic [WidthBits-1:0] WidthMax   = WidthBits'(64);

  typedef enum logic [CfgIdxBits-1:0] {
    RegValueWidth = 2'd0,
    RegValueCount = 2'd1
  } cfg_reg_e;

  // Active configuration seen by the extraction side.
  typedef struct packed {
    logic [WidthBits-1:0] width;  // already clamped to 1..64
    logic [CountBits-1:0] count;
  } cfg_t;

  // One queued word with its classification.
  typedef struct packed {
    logic [DataBits-1:0] word;
    logic                first;  // first word of a run
  } entry_t;

  // Ones in the low n bits; a shift by 64 or more yields zero, so n = 64 gives all ones.
  function automatic logic [DataBits-1:0] low_mask(input logic [WidthBits-1:0] n);
    low_mask = ~({DataBits{1'b1}} << n);
  endfunction

endpackage

// File: rtl/core/fixed_width_field_unpacker_top.sv
// Top level of the fixed-width field unpacker.
//
// Input stream (s_axis_*): 64-bit words, bit 63 read first, accepted when tvalid and
// tready are both high. Output stream (m_axis_*): one unpacked value per transfer,
// zero-extended to 64 bits in tdata; tlast marks the final value of a run.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 = value width,
// 1 = value count). Any write to a known register aborts the run and returns to idle.
// A word arriving while idle with a nonzero count starts a run of value_count values;
// after the last one further words are taken and dropped until the next register write.
// With the extractor empty, the first value of a word goes from the queue into the word
// register and then into the output register.
// The extractor emits at most one value per cycle; a word whose tail does not complete
// a value also needs a separate step that moves that tail into the residual. Widths
// that divide 64 never need that step, and width 64 sustains one word per cycle while
// the output is not stalled. Words pass through a two-entry queue, so input transfers
// continue while the output register holds a result.
// When the receiver stalls, the output register holds, the extractor stops and the
// queue fills, after which s_axis_tready_o drops.
// Reset clears the run state and the queue and loads width 8 and count 0.
module fixed_width_field_unpacker_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fwfu_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [fwfu_pkg::CfgDataBits-1:0]   cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [63:0]                        s_axis_tdata_i,  // [63:0] word
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [63:0]                        m_axis_tdata_o,  // [63:0] value
  output logic                               m_axis_tlast_o   // last_value
);

  fwfu_pkg::cfg_t   cfg;
  fwfu_pkg::entry_t push_entry;
  fwfu_pkg::entry_t head;
  logic             push, pop, flush, fifo_full, head_valid;

  fwfu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_word_i    (s_axis_tdata_i),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .push_entry_o (push_entry),
    .cfg_o        (cfg),
    .flush_o      (flush)
  );

  fwfu_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .flush_i      (flush),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (fifo_full),
    .valid_o      (head_valid),
    .pop_i        (pop),
    .head_o       (head)
  );

  fwfu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .flush_i      (flush),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_value_o  (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

// File: rtl/core/fwfu_front.sv
// Front end: configuration registers, run tracking and word classification.
module fwfu_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [fwfu_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [fwfu_pkg::CfgDataBits-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [fwfu_pkg::DataBits-1:0]         in_word_i,
  input  logic                                  fifo_full_i,
  output logic                                  push_o,
  output fwfu_pkg::entry_t                      push_entry_o,
  output fwfu_pkg::cfg_t                        cfg_o,
  output logic                                  flush_o
);

  logic [fwfu_pkg::WidthBits-1:0] width_q, width_d;
  logic [fwfu_pkg::CountBits-1:0] count_q, count_d;
  logic                           active_q, active_d;
  logic                           accept;
  logic                           cfg_hit;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == fwfu_pkg::RegValueWidth ||
                                cfg_idx_i == fwfu_pkg::RegValueCount);
  assign flush_o = cfg_hit;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    width_d = width_q;
    count_d = count_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        fwfu_pkg::RegValueWidth: width_d = cfg_data_i[fwfu_pkg::WidthBits-1:0];
        fwfu_pkg::RegValueCount: count_d = cfg_data_i[fwfu_pkg::CountBits-1:0];
        default: ;
      endcase
    end
  end

  // A word that arrives while idle with a zero count is dropped and the block stays idle.
  always_comb begin
    active_d = active_q;
    push_o   = 1'b0;
    if (accept && (active_q || count_q != '0)) begin
      push_o   = 1'b1;
      active_d = 1'b1;
    end
    if (cfg_hit) begin
      active_d = 1'b0;
    end
  end

  assign push_entry_o.word  = in_word_i &
                              fwfu_pkg::low_mask(fwfu_pkg::WidthBits'(fwfu_pkg::WordBits));
  assign push_entry_o.first = !active_q;

  always_comb begin
    cfg_o.count = count_q;
    if (width_q == '0) begin
      cfg_o.width = fwfu_pkg::WidthBits'(1);
    end else if (width_q > fwfu_pkg::WidthMax) begin
      cfg_o.width = fwfu_pkg::WidthMax;
    end else begin
      cfg_o.width = width_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= fwfu_pkg::WidthReset;
      count_q  <= '0;
      active_q <= 1'b0;
    end else begin
      width_q  <= width_d;
      count_q  <= count_d;
      active_q <= active_d;
    end
  end

endmodule

// File: rtl/core/fwfu_fifo.sv
// Short queue of classified words between the front end and the extractor.
module fwfu_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             flush_i,
  input  logic             push_i,
  input  fwfu_pkg::entry_t push_entry_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output fwfu_pkg::entry_t head_o
);

  fwfu_pkg::entry_t mem_q [fwfu_pkg::FifoDepth];
  logic [fwfu_pkg::FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [fwfu_pkg::FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [fwfu_pkg::FifoCntW-1:0] cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == fwfu_pkg::FifoCntW'(fwfu_pkg::FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == fwfu_pkg::FifoPtrW'(fwfu_pkg::FifoDepth - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == fwfu_pkg::FifoPtrW'(fwfu_pkg::FifoDepth - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
    if (flush_i) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
      cnt_d    = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= fwfu_pkg::FifoCntW'(fwfu_pkg::FifoDepth))
    else $error("queue count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop && !flush_i) |=> valid_o)
    else $error("pushed word not visible at the head");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_i |=> !valid_o)
    else $error("flush left words in the queue");

endmodule

// File: rtl/core/fwfu_back.sv
// Back end: cuts queued words into values, holds the residual and drives the output register.
module fwfu_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fwfu_pkg::cfg_t                cfg_i,
  input  logic                          flush_i,
  input  logic                          head_valid_i,
  input  fwfu_pkg::entry_t              head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fwfu_pkg::DataBits-1:0] out_value_o,
  output logic                          out_last_o
);

  logic [fwfu_pkg::DataBits-1:0]  word_q, word_d;
  logic [fwfu_pkg::DataBits-1:0]  res_q, res_d;
  logic [fwfu_pkg::DataBits-1:0]  value_q, value_d;
  logic [fwfu_pkg::PosW-1:0]      pos_q, pos_d;
  logic [fwfu_pkg::WidthBits-1:0] rc_q, rc_d;
  logic [fwfu_pkg::CountBits-1:0] left_q, left_d;
  logic                           done_q, done_d;
  logic                           ovalid_q, ovalid_d;
  logic                           last_q, last_d;

  logic [fwfu_pkg::WidthBits-1:0] need;
  logic [fwfu_pkg::WidthBits-1:0] pos_w;
  logic                           take;
  logic                           slot_free;
  logic [fwfu_pkg::DataBits-1:0]  field_bits;

  assign pos_w     = fwfu_pkg::WidthBits'(pos_q);
  assign need      = cfg_i.width - rc_q;
  assign take      = (need <= pos_w);
  assign slot_free = !ovalid_q || out_ready_i;
  // Remaining bits of the current word sit in its low pos bits, most significant first.
  assign field_bits = (word_q >> (pos_w - need)) & fwfu_pkg::low_mask(need);

  always_comb begin
    word_d   = word_q;
    res_d    = res_q;
    value_d  = value_q;
    pos_d    = pos_q;
    rc_d     = rc_q;
    left_d   = left_q;
    done_d   = done_q;
    ovalid_d = ovalid_q;
    last_d   = last_q;
    pop_o    = 1'b0;

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    if (pos_q != '0) begin
      if (take) begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          value_d  = ((res_q << need) | field_bits) & fwfu_pkg::low_mask(cfg_i.width);
          last_d   = (left_q == fwfu_pkg::CountBits'(1));
          left_d   = left_q - 1'b1;
          pos_d    = fwfu_pkg::PosW'(pos_w - need);
          res_d    = '0;
          rc_d     = '0;
          if (left_q == fwfu_pkg::CountBits'(1)) begin
            // Final value: the rest of this word is dropped.
            done_d = 1'b1;
            pos_d  = '0;
          end
        end
      end else begin
        res_d = (res_q << pos_w) | (word_q & fwfu_pkg::low_mask(pos_w));
        rc_d  = rc_q + pos_w;
        pos_d = '0;
      end
    end

    if (head_valid_i && pos_d == '0) begin
      pop_o = 1'b1;
      if (head_i.first) begin
        word_d = head_i.word;
        pos_d  = fwfu_pkg::PosW'(fwfu_pkg::WordBits);
        left_d = cfg_i.count;
        res_d  = '0;
        rc_d   = '0;
        done_d = 1'b0;
      end else if (!done_d) begin
        word_d = head_i.word;
        pos_d  = fwfu_pkg::PosW'(fwfu_pkg::WordBits);
      end
    end

    if (flush_i) begin
      pos_d  = '0;
      res_d  = '0;
      rc_d   = '0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    res_q   <= res_d;
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      rc_q     <= '0;
      left_q   <= '0;
      done_q   <= 1'b1;
      ovalid_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      rc_q     <= rc_d;
      left_q   <= left_d;
      done_q   <= done_d;
      ovalid_q <= ovalid_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_value_o = value_q;
  assign out_last_o  = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= fwfu_pkg::PosW'(fwfu_pkg::WordBits))
    else $error("bit position beyond word size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (pos_q == '0 && rc_q == '0))
    else $error("finished run still holds bits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != '0 && take && slot_free && !flush_i) |=> ovalid_q)
    else $error("extracted value did not reach the output register");

endmodule
